FILE: design/tsms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsms_pkg
// Shared types and constants of the track signal message scheduler.
// ----------------------------------------------------------------------------
package tsms_pkg;

    localparam int WORD_W      = 18;
    localparam int SLOT_FIELD_W = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int PERIOD_W    = 16;
    localparam int HIGH_W      = 9;

    // clocks per bit and PWM high times
    localparam int PERIOD_FAST = 208;
    localparam int PERIOD_SLOW = 416;
    localparam int HIGH_ONE    = 182;
    localparam int HIGH_ZERO   = 26;
    localparam int PERIOD_MAX  = 65535;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_FAST    = 3'd4,
        OP_ONESHOT = 3'd5,
        OP_START   = 3'd6,
        OP_FAULT   = 3'd7
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_MESSAGE = 1'b0,
        CFG_IDLE_FAST    = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_LOAD,
        S_LWAIT,
        S_READ,
        S_RESP
    } back_state_t;

    // decoded command passed from front to back
    typedef struct packed {
        op_t                     op;
        logic                    ok;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [WORD_W-1:0]       word;
        logic                    flag;
    } cmd_t;

    typedef struct packed {
        logic                slot_enabled;
        logic [WORD_W-1:0]   slot_message;
        logic                rail_off;
        logic                line_bit;
        logic [HIGH_W-1:0]   high_count;
        logic [PERIOD_W-1:0] period_count;
        logic                drive_valid;
    } res_t;

endpackage

FILE: design/tsms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsms_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsms_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/tsms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsms_front
// Accepts input words, decodes them into commands and queues them.
// ----------------------------------------------------------------------------
module tsms_front
    import tsms_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              in_op,
    input  logic [SLOT_FIELD_W-1:0] in_slot,
    input  logic [WORD_W-1:0]       in_word,
    input  logic                    in_flag,
    output logic                    q_valid,
    input  logic                    q_pop,
    output cmd_t                    q_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       dec;

    always_comb
    begin
        dec.op   = op_t'(in_op);
        dec.ok   = (32'(in_slot) < SLOTS);
        dec.slot = in_slot;
        dec.word = in_word;
        dec.flag = in_flag;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

FILE: design/tsms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsms_back
// Executes queued commands: slot flags, bit timing, round-robin reload,
// and the registered result word.
// ----------------------------------------------------------------------------
module tsms_back
    import tsms_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int MESSAGE_BITS = 18,
    parameter int GAP_BITS     = 3,
    parameter int WAIT_BITS    = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  cmd_t                 q_cmd,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [WORD_W-1:0]    cfg_wdata,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int BI_W   = $clog2(MESSAGE_BITS);

    localparam int FG_RAW = PERIOD_FAST * (GAP_BITS + 1);
    localparam int SG_RAW = PERIOD_SLOW * (GAP_BITS + 1);
    localparam int FW_RAW = PERIOD_FAST * (WAIT_BITS + 1);
    localparam int SW_RAW = PERIOD_SLOW * (WAIT_BITS + 1);
    localparam logic [PERIOD_W-1:0] P_FAST = PERIOD_W'(PERIOD_FAST);
    localparam logic [PERIOD_W-1:0] P_SLOW = PERIOD_W'(PERIOD_SLOW);
    localparam logic [PERIOD_W-1:0] P_FAST_GAP =
        PERIOD_W'(FG_RAW > PERIOD_MAX ? PERIOD_MAX : FG_RAW);
    localparam logic [PERIOD_W-1:0] P_SLOW_GAP =
        PERIOD_W'(SG_RAW > PERIOD_MAX ? PERIOD_MAX : SG_RAW);
    localparam logic [PERIOD_W-1:0] P_FAST_WAIT =
        PERIOD_W'(FW_RAW > PERIOD_MAX ? PERIOD_MAX : FW_RAW);
    localparam logic [PERIOD_W-1:0] P_SLOW_WAIT =
        PERIOD_W'(SW_RAW > PERIOD_MAX ? PERIOD_MAX : SW_RAW);
    localparam logic [BI_W-1:0] BI_LAST = BI_W'(MESSAGE_BITS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [SLOTS-1:0]     enable_reg, enable_next;
    logic [SLOTS-1:0]     fast_reg, fast_next;
    logic [SLOTS-1:0]     oneshot_reg, oneshot_next;
    logic [SLOT_W-1:0]    cur_slot_reg, cur_slot_next;
    logic                 repeat_reg, repeat_next;
    logic [BI_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [WORD_W-1:0]    cur_word_reg, cur_word_next;
    logic                 cur_fast_reg, cur_fast_next;
    logic                 running_reg, running_next;
    logic [WORD_W-1:0]    idle_msg_reg, idle_msg_next;
    logic                 idle_fast_reg, idle_fast_next;
    logic                 tick_run_reg, tick_run_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_reg, res_next;

    logic [SLOT_W-1:0]    cmd_idx;
    logic [SLOT_W-1:0]    cand;
    logic [SLOT_W-1:0]    raddr;
    logic                 ram_we;
    logic [WORD_W-1:0]    rdata;
    logic [31:0]          word_ext;
    logic                 out_bit;

    assign cmd_idx  = SLOT_W'(cmd_reg.slot);
    assign cand     = (cur_slot_reg == SLOT_LAST) ? '0 : cur_slot_reg + SLOT_W'(1);
    assign raddr    = (state_reg == S_LOAD) ? cur_slot_reg : cmd_idx;
    assign ram_we   = (state_reg == S_EXEC) && (cmd_reg.op == OP_WRITE) && cmd_reg.ok;
    assign word_ext = 32'(cur_word_reg);
    assign out_bit  = word_ext[5'(bit_idx_reg)];

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    tsms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd_idx),
        .wdata (cmd_reg.word),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        enable_next    = enable_reg;
        fast_next      = fast_reg;
        oneshot_next   = oneshot_reg;
        cur_slot_next  = cur_slot_reg;
        repeat_next    = repeat_reg;
        bit_idx_next   = bit_idx_reg;
        cur_word_next  = cur_word_reg;
        cur_fast_next  = cur_fast_reg;
        running_next   = running_reg;
        idle_msg_next  = idle_msg_reg;
        idle_fast_next = idle_fast_reg;
        tick_run_next  = tick_run_reg;
        period_next    = period_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;

        if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_IDLE_MESSAGE: idle_msg_next  = cfg_wdata;
                CFG_IDLE_FAST:    idle_fast_next = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                tick_run_next = 1'b0;
                state_next    = S_READ;
                unique case (cmd_reg.op)
                    OP_TICK:
                    begin
                        if (running_reg)
                        begin
                            tick_run_next = 1'b1;
                            if (bit_idx_reg >= BI_LAST)
                            begin
                                bit_idx_next = '0;
                                repeat_next  = !repeat_reg;
                                if (repeat_reg)
                                begin
                                    period_next = cur_fast_reg ? P_FAST_WAIT : P_SLOW_WAIT;
                                    if (enable_reg != '0)
                                    begin
                                        state_next = S_SEARCH;
                                    end
                                    else
                                    begin
                                        cur_word_next = idle_msg_reg;
                                        cur_fast_next = idle_fast_reg;
                                    end
                                end
                                else
                                begin
                                    period_next = cur_fast_reg ? P_FAST_GAP : P_SLOW_GAP;
                                end
                            end
                            else
                            begin
                                bit_idx_next = bit_idx_reg + BI_W'(1);
                                period_next  = cur_fast_reg ? P_FAST : P_SLOW;
                            end
                        end
                    end
                    OP_WRITE: ;
                    OP_ENABLE:
                    begin
                        if (cmd_reg.ok)
                        begin
                            enable_next[cmd_idx] = 1'b1;
                        end
                    end
                    OP_DISABLE:
                    begin
                        if (cmd_reg.ok)
                        begin
                            enable_next[cmd_idx] = 1'b0;
                        end
                    end
                    OP_FAST:
                    begin
                        if (cmd_reg.ok)
                        begin
                            fast_next[cmd_idx] = cmd_reg.flag;
                        end
                    end
                    OP_ONESHOT:
                    begin
                        if (cmd_reg.ok)
                        begin
                            oneshot_next[cmd_idx] = cmd_reg.flag;
                        end
                    end
                    OP_START:
                    begin
                        enable_next   = '0;
                        fast_next     = '0;
                        oneshot_next  = '0;
                        cur_slot_next = '0;
                        cur_word_next = idle_msg_reg;
                        cur_fast_next = idle_fast_reg;
                        repeat_next   = 1'b0;
                        bit_idx_next  = '0;
                        running_next  = 1'b1;
                    end
                    OP_FAULT:
                    begin
                        running_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_SEARCH:
            begin
                // one slot per cycle; the mask is known to be nonzero
                cur_slot_next = cand;
                if (enable_reg[cand])
                begin
                    if (oneshot_reg[cand])
                    begin
                        enable_next[cand] = 1'b0;
                    end
                    cur_fast_next = fast_reg[cand];
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                cur_word_next = rdata;
                state_next    = S_READ;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next        = 1'b1;
                    res_next.drive_valid  = tick_run_reg;
                    res_next.period_count = tick_run_reg ? period_reg : '0;
                    res_next.line_bit     = tick_run_reg && out_bit;
                    if (!tick_run_reg)
                    begin
                        res_next.high_count = '0;
                    end
                    else if (out_bit)
                    begin
                        res_next.high_count = cur_fast_reg ? HIGH_W'(HIGH_ONE)
                                                           : HIGH_W'(2 * HIGH_ONE);
                    end
                    else
                    begin
                        res_next.high_count = cur_fast_reg ? HIGH_W'(HIGH_ZERO)
                                                           : HIGH_W'(2 * HIGH_ZERO);
                    end
                    res_next.rail_off     = !running_reg;
                    res_next.slot_message = cmd_reg.ok ? rdata : idle_msg_reg;
                    res_next.slot_enabled = cmd_reg.ok && enable_reg[cmd_idx];
                    state_next            = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= '0;
            fast_reg      <= '0;
            oneshot_reg   <= '0;
            cur_slot_reg  <= '0;
            repeat_reg    <= 1'b0;
            bit_idx_reg   <= '0;
            cur_word_reg  <= '0;
            cur_fast_reg  <= 1'b0;
            running_reg   <= 1'b0;
            idle_msg_reg  <= '0;
            idle_fast_reg <= 1'b0;
            tick_run_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            fast_reg      <= fast_next;
            oneshot_reg   <= oneshot_next;
            cur_slot_reg  <= cur_slot_next;
            repeat_reg    <= repeat_next;
            bit_idx_reg   <= bit_idx_next;
            cur_word_reg  <= cur_word_next;
            cur_fast_reg  <= cur_fast_next;
            running_reg   <= running_next;
            idle_msg_reg  <= idle_msg_next;
            idle_fast_reg <= idle_fast_next;
            tick_run_reg  <= tick_run_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        period_reg <= period_next;
        res_reg    <= res_next;
    end

endmodule

FILE: design/track_signal_message_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_signal_message_scheduler
// Slot store with enable/fast/one-shot flags; sends each message twice and
// reports PWM period and high time per bit tick.
// ----------------------------------------------------------------------------
// channel   dir  handshake                fields (low bit first)
// s_axis    in   s_axis_tvalid/tready     tuser: op; tdata: slot, message_word, flag
// m_axis    out  m_axis_tvalid/tready     tdata: drive_valid, period_count,
//                                         high_count, line_bit, rail_off,
//                                         slot_message, slot_enabled
// cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
// In the back end a word is popped, executed, read from the store and then
// returned as a result. A tick that ends a repeat with slots enabled adds a
// round-robin search, which steps one slot per cycle, then a store read.
// The front queue holds two words, so input is taken while the back works.
// Reset clears all control state; the message store is not cleared.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module track_signal_message_scheduler
    import tsms_pkg::*;
#(
    parameter int SLOTS        = 8,
    parameter int MESSAGE_BITS = 18,
    parameter int GAP_BITS     = 3,
    parameter int WAIT_BITS    = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // slot, message_word, flag
    input  logic [2:0]           s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // drive_valid, period_count,
                                                 // high_count, line_bit, rail_off,
                                                 // slot_message, slot_enabled
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;
    res_t res;

    assign cfg_ready = 1'b1;

    tsms_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_slot  (s_axis_tdata[2:0]),
        .in_word  (s_axis_tdata[20:3]),
        .in_flag  (s_axis_tdata[21]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    tsms_back #(
        .SLOTS        (SLOTS),
        .MESSAGE_BITS (MESSAGE_BITS),
        .GAP_BITS     (GAP_BITS),
        .WAIT_BITS    (WAIT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {1'b0, res};

endmodule
